/* rtl/svpf_pkg.sv */
`default_nettype none
package svpf_pkg;

  localparam int unsigned POS_W       = 12;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned BYTE_IDX_W  = 5;

  typedef enum logic [0:0] {
    OP_SINGLE = 1'b0,
    OP_SYNC   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_MIN   = 3'd0,
    CFG_ONE_MAX   = 3'd1,
    CFG_TWO_MIN   = 3'd2,
    CFG_TWO_MAX   = 3'd3,
    CFG_MOVE_TIME = 3'd4
  } cfg_idx_e;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] SINGLE_LEN    = 8'h07;
  localparam logic [7:0] SINGLE_CMD    = 8'h03;
  localparam logic [7:0] POS_ADDR      = 8'h2A;
  localparam logic [7:0] BCAST_ID      = 8'hFE;
  localparam logic [7:0] SYNC_LEN      = 8'h0E;
  localparam logic [7:0] SYNC_CMD      = 8'h83;
  localparam logic [7:0] SYNC_DATA_LEN = 8'h04;

  localparam logic [ID_W-1:0]  ID_ONE   = 8'd1;
  localparam logic [ID_W-1:0]  ID_TWO   = 8'd2;
  localparam logic [POS_W-1:0] FULL_MIN = 12'd0;
  localparam logic [POS_W-1:0] FULL_MAX = 12'd4095;

  localparam logic [POS_W-1:0]  RST_ONE_MIN   = 12'd600;
  localparam logic [POS_W-1:0]  RST_ONE_MAX   = 12'd3600;
  localparam logic [POS_W-1:0]  RST_TWO_MIN   = 12'd1300;
  localparam logic [POS_W-1:0]  RST_TWO_MAX   = 12'd4095;
  localparam logic [TIME_W-1:0] RST_MOVE_TIME = 16'd10;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id_a;
    logic [POS_W-1:0] pos_a;
    logic [ID_W-1:0] id_b;
    logic [POS_W-1:0] pos_b;
  } cmd_t;

  function automatic logic [POS_W-1:0] clamp_pos(
    input logic signed [ANGLE_W-1:0] angle,
    input logic [POS_W-1:0]          lo,
    input logic [POS_W-1:0]          hi
  );
    logic signed [ANGLE_W:0] a;
    logic signed [ANGLE_W:0] l;
    logic signed [ANGLE_W:0] h;
    logic [POS_W-1:0]        r;
    a = {angle[ANGLE_W-1], angle};
    l = $signed({{(ANGLE_W+1-POS_W){1'b0}}, lo});
    h = $signed({{(ANGLE_W+1-POS_W){1'b0}}, hi});
    if (a < l) begin
      r = lo;
    end else if (a > h) begin
      r = hi;
    end else begin
      r = angle[POS_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/svpf_front.sv */
`default_nettype none
module svpf_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [svpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [svpf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 operation,
  input  wire logic [svpf_pkg::ID_W-1:0]            servo_id_a,
  input  wire logic signed [svpf_pkg::ANGLE_W-1:0]  angle_a,
  input  wire logic [svpf_pkg::ID_W-1:0]            servo_id_b,
  input  wire logic signed [svpf_pkg::ANGLE_W-1:0]  angle_b,
  output logic                                      push,
  output svpf_pkg::cmd_t                            push_cmd,
  input  wire logic                                 q_full,
  output logic [svpf_pkg::TIME_W-1:0]               move_time
);

  logic [svpf_pkg::POS_W-1:0] one_min;
  logic [svpf_pkg::POS_W-1:0] one_max;
  logic [svpf_pkg::POS_W-1:0] two_min;
  logic [svpf_pkg::POS_W-1:0] two_max;

  logic                       hold_valid;
  svpf_pkg::cmd_t             hold;
  svpf_pkg::cmd_t             hold_next;
  logic                       take;
  logic [svpf_pkg::POS_W-1:0] lo_a, hi_a, lo_b, hi_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_min   <= svpf_pkg::RST_ONE_MIN;
      one_max   <= svpf_pkg::RST_ONE_MAX;
      two_min   <= svpf_pkg::RST_TWO_MIN;
      two_max   <= svpf_pkg::RST_TWO_MAX;
      move_time <= svpf_pkg::RST_MOVE_TIME;
    end else if (cfg_write) begin
      unique case (cfg_index)
        svpf_pkg::CFG_ONE_MIN:   one_min   <= cfg_data[svpf_pkg::POS_W-1:0];
        svpf_pkg::CFG_ONE_MAX:   one_max   <= cfg_data[svpf_pkg::POS_W-1:0];
        svpf_pkg::CFG_TWO_MIN:   two_min   <= cfg_data[svpf_pkg::POS_W-1:0];
        svpf_pkg::CFG_TWO_MAX:   two_max   <= cfg_data[svpf_pkg::POS_W-1:0];
        svpf_pkg::CFG_MOVE_TIME: move_time <= cfg_data[svpf_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (servo_id_a == svpf_pkg::ID_ONE) begin
      lo_a = one_min;
      hi_a = one_max;
    end else if (servo_id_a == svpf_pkg::ID_TWO) begin
      lo_a = two_min;
      hi_a = two_max;
    end else begin
      lo_a = svpf_pkg::FULL_MIN;
      hi_a = svpf_pkg::FULL_MAX;
    end
    priority if (servo_id_b == svpf_pkg::ID_ONE) begin
      lo_b = one_min;
      hi_b = one_max;
    end else if (servo_id_b == svpf_pkg::ID_TWO) begin
      lo_b = two_min;
      hi_b = two_max;
    end else begin
      lo_b = svpf_pkg::FULL_MIN;
      hi_b = svpf_pkg::FULL_MAX;
    end
    hold_next.op    = svpf_pkg::op_e'(operation);
    hold_next.id_a  = servo_id_a;
    hold_next.pos_a = svpf_pkg::clamp_pos(angle_a, lo_a, hi_a);
    hold_next.id_b  = servo_id_b;
    hold_next.pos_b = svpf_pkg::clamp_pos(angle_b, lo_b, hi_b);
  end

  assign in_stall = hold_valid && q_full;
  assign take     = in_valid && !in_stall;
  assign push     = hold_valid && !q_full;
  assign push_cmd = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= take || (hold_valid && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= hold_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/svpf_queue.sv */
`default_nettype none
module svpf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire svpf_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output svpf_pkg::cmd_t      head_cmd
);

  localparam int unsigned PTR_W = $clog2(svpf_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(svpf_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(svpf_pkg::QUEUE_DEPTH);

  svpf_pkg::cmd_t   slots [svpf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == DEPTH_CNT);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(svpf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(svpf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/svpf_back.sv */
`default_nettype none
module svpf_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        head_valid,
  input  wire svpf_pkg::cmd_t              head_cmd,
  output logic                             pop,
  input  wire logic [svpf_pkg::TIME_W-1:0] move_time,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       packet_byte,
  output logic                             last_byte
);

  localparam int unsigned IW = svpf_pkg::BYTE_IDX_W;
  localparam logic [IW-1:0] LAST_SINGLE = IW'(10);
  localparam logic [IW-1:0] LAST_SYNC   = IW'(17);
  localparam logic [IW-1:0] FIRST_SUM   = IW'(2);

  svpf_pkg::cmd_t cur;
  logic           busy;
  logic [IW-1:0]  idx;
  logic [7:0]     sum;
  logic           load;
  logic           is_last;
  logic [7:0]     byte_next;
  logic [7:0]     pa_hi, pa_lo, pb_hi, pb_lo, t_hi, t_lo;

  assign pa_hi = {{(16-svpf_pkg::POS_W){1'b0}}, cur.pos_a[svpf_pkg::POS_W-1:8]};
  assign pa_lo = cur.pos_a[7:0];
  assign pb_hi = {{(16-svpf_pkg::POS_W){1'b0}}, cur.pos_b[svpf_pkg::POS_W-1:8]};
  assign pb_lo = cur.pos_b[7:0];
  assign t_hi  = move_time[15:8];
  assign t_lo  = move_time[7:0];

  assign is_last = (idx == ((cur.op == svpf_pkg::OP_SYNC) ? LAST_SYNC : LAST_SINGLE));
  assign load    = busy && (!out_valid || !out_stall);
  assign pop     = head_valid && (!busy || (load && is_last));

  always_comb begin
    byte_next = 8'h00;
    if (is_last) begin
      byte_next = ~sum;
    end else if (cur.op == svpf_pkg::OP_SYNC) begin
      unique case (idx)
        IW'(0), IW'(1): byte_next = svpf_pkg::HDR_BYTE;
        IW'(2):         byte_next = svpf_pkg::BCAST_ID;
        IW'(3):         byte_next = svpf_pkg::SYNC_LEN;
        IW'(4):         byte_next = svpf_pkg::SYNC_CMD;
        IW'(5):         byte_next = svpf_pkg::POS_ADDR;
        IW'(6):         byte_next = svpf_pkg::SYNC_DATA_LEN;
        IW'(7):         byte_next = cur.id_a;
        IW'(8):         byte_next = pa_hi;
        IW'(9):         byte_next = pa_lo;
        IW'(10):        byte_next = t_hi;
        IW'(11):        byte_next = t_lo;
        IW'(12):        byte_next = cur.id_b;
        IW'(13):        byte_next = pb_hi;
        IW'(14):        byte_next = pb_lo;
        IW'(15):        byte_next = t_hi;
        IW'(16):        byte_next = t_lo;
        default:        byte_next = 8'h00;
      endcase
    end else begin
      unique case (idx)
        IW'(0), IW'(1): byte_next = svpf_pkg::HDR_BYTE;
        IW'(2):         byte_next = cur.id_a;
        IW'(3):         byte_next = svpf_pkg::SINGLE_LEN;
        IW'(4):         byte_next = svpf_pkg::SINGLE_CMD;
        IW'(5):         byte_next = svpf_pkg::POS_ADDR;
        IW'(6):         byte_next = pa_hi;
        IW'(7):         byte_next = pa_lo;
        IW'(8):         byte_next = t_hi;
        IW'(9):         byte_next = t_lo;
        default:        byte_next = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (load && is_last) begin
        busy <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_cmd;
      idx <= '0;
      sum <= 8'h00;
    end else if (load) begin
      idx <= idx + 1'b1;
      if (idx >= FIRST_SUM) begin
        sum <= sum + byte_next;
      end
    end
    if (load) begin
      packet_byte <= byte_next;
      last_byte   <= is_last;
    end
  end

endmodule
`default_nettype wire

/* rtl/servo_position_packet_framer.sv */
`default_nettype none
// Channel  | Handshake               | Word
// ---------+-------------------------+------------------------------------------------
// cfg      | cfg_write               | cfg_index, cfg_data
// in       | in_valid / in_stall     | operation, servo_id_a, angle_a, servo_id_b, angle_b
// out      | out_valid / out_stall   | packet_byte, last_byte
//
// One output word per cycle while out_stall is low: 11 bytes per single-write command,
// 18 per sync command, set by the byte serializer. Input sits in a capture register with
// clamping, then a 2-entry queue, so commands keep arriving while a packet streams out.
// If idle, a taken command passes capture register, queue, command register, then output.
// Synchronous reset restores the clamp limits and move time and empties the pipeline.
// out_stall holds the output register; in_stall rises only when the queue is full.
module servo_position_packet_framer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [svpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [svpf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 operation,
  input  wire logic [svpf_pkg::ID_W-1:0]            servo_id_a,
  input  wire logic signed [svpf_pkg::ANGLE_W-1:0]  angle_a,
  input  wire logic [svpf_pkg::ID_W-1:0]            servo_id_b,
  input  wire logic signed [svpf_pkg::ANGLE_W-1:0]  angle_b,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [7:0]                                packet_byte,
  output logic                                      last_byte
);

  logic                              push;
  svpf_pkg::cmd_t                    push_cmd;
  logic                              q_full;
  logic                              pop;
  logic                              head_valid;
  svpf_pkg::cmd_t                    head_cmd;
  logic [svpf_pkg::TIME_W-1:0]       move_time;

  svpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .servo_id_a (servo_id_a),
    .angle_a    (angle_a),
    .servo_id_b (servo_id_b),
    .angle_b    (angle_b),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full),
    .move_time  (move_time)
  );

  svpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  svpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .move_time   (move_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packet_byte (packet_byte),
    .last_byte   (last_byte)
  );

endmodule
`default_nettype wire

/* tb/servo_position_packet_framer_test.sv */
`default_nettype none
module servo_position_packet_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT       = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int LONG_HOLD_AFTER  = 350;
  localparam int SETTLE_CYCLES    = 10;

  localparam logic [svpf_pkg::CFG_IDX_W-1:0] BAD_INDEX_LO = 3'd5;
  localparam logic [svpf_pkg::CFG_IDX_W-1:0] BAD_INDEX_HI = 3'd7;

  typedef struct packed {
    svpf_pkg::op_e                       op;
    logic [svpf_pkg::ID_W-1:0]           id_a;
    logic signed [svpf_pkg::ANGLE_W-1:0] angle_a;
    logic [svpf_pkg::ID_W-1:0]           id_b;
    logic signed [svpf_pkg::ANGLE_W-1:0] angle_b;
  } servo_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef enum int {
    FLOW,
    COIN,
    PATTERN,
    CHOKE,
    HOLD
  } stall_mode_e;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [svpf_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [svpf_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                operation = 1'b0;
  logic [svpf_pkg::ID_W-1:0]           servo_id_a = '0;
  logic signed [svpf_pkg::ANGLE_W-1:0] angle_a = '0;
  logic [svpf_pkg::ID_W-1:0]           servo_id_b = '0;
  logic signed [svpf_pkg::ANGLE_W-1:0] angle_b = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [7:0]                          packet_byte;
  logic                                last_byte;

  logic [svpf_pkg::POS_W-1:0]  one_lo = svpf_pkg::RST_ONE_MIN;
  logic [svpf_pkg::POS_W-1:0]  one_hi = svpf_pkg::RST_ONE_MAX;
  logic [svpf_pkg::POS_W-1:0]  two_lo = svpf_pkg::RST_TWO_MIN;
  logic [svpf_pkg::POS_W-1:0]  two_hi = svpf_pkg::RST_TWO_MAX;
  logic [svpf_pkg::TIME_W-1:0] move_ticks = svpf_pkg::RST_MOVE_TIME;

  servo_cmd_t  cmd_backlog[$];
  frame_byte_t bytes_due[$];
  servo_cmd_t  next_cmd;
  frame_byte_t due_byte;

  int cmds_queued = 0;
  int cmds_taken = 0;
  int bytes_seen = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;

  int burst_left = 0;
  int gap_left = 0;

  stall_mode_e stall_mode = FLOW;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  logic [7:0]  stall_pattern = '0;
  int          pattern_pos = 0;

  servo_position_packet_framer i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .servo_id_a  (servo_id_a),
    .angle_a     (angle_a),
    .servo_id_b  (servo_id_b),
    .angle_b     (angle_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packet_byte (packet_byte),
    .last_byte   (last_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [svpf_pkg::POS_W-1:0] limit_position(
    logic [svpf_pkg::ID_W-1:0] id,
    logic signed [svpf_pkg::ANGLE_W-1:0] angle
  );
    int lo;
    int hi;
    int a;
    int r;
    lo = 0;
    hi = int'(svpf_pkg::FULL_MAX);
    a = int'(angle);
    if (id == svpf_pkg::ID_ONE) begin
      lo = int'(one_lo);
      hi = int'(one_hi);
    end else if (id == svpf_pkg::ID_TWO) begin
      lo = int'(two_lo);
      hi = int'(two_hi);
    end
    if (a < lo) begin
      r = lo;
    end else if (a > hi) begin
      r = hi;
    end else begin
      r = a;
    end
    return r[svpf_pkg::POS_W-1:0];
  endfunction

  function automatic void frame_packet(servo_cmd_t c);
    logic [7:0]                 body[$];
    logic [7:0]                 sum;
    logic [svpf_pkg::POS_W-1:0] pa;
    logic [svpf_pkg::POS_W-1:0] pb;
    pa = limit_position(c.id_a, c.angle_a);
    pb = limit_position(c.id_b, c.angle_b);
    if (c.op == svpf_pkg::OP_SINGLE) begin
      body = '{c.id_a, svpf_pkg::SINGLE_LEN, svpf_pkg::SINGLE_CMD, svpf_pkg::POS_ADDR,
               {4'h0, pa[11:8]}, pa[7:0], move_ticks[15:8], move_ticks[7:0]};
    end else begin
      body = '{svpf_pkg::BCAST_ID, svpf_pkg::SYNC_LEN, svpf_pkg::SYNC_CMD,
               svpf_pkg::POS_ADDR, svpf_pkg::SYNC_DATA_LEN,
               c.id_a, {4'h0, pa[11:8]}, pa[7:0], move_ticks[15:8], move_ticks[7:0],
               c.id_b, {4'h0, pb[11:8]}, pb[7:0], move_ticks[15:8], move_ticks[7:0]};
    end
    sum = '0;
    bytes_due.push_back('{svpf_pkg::HDR_BYTE, 1'b0});
    bytes_due.push_back('{svpf_pkg::HDR_BYTE, 1'b0});
    foreach (body[i]) begin
      sum = sum + body[i];
      bytes_due.push_back('{body[i], 1'b0});
    end
    bytes_due.push_back('{~sum, 1'b1});
  endfunction

  function automatic logic [svpf_pkg::ID_W-1:0] pick_id();
    logic [svpf_pkg::ID_W-1:0] id;
    case ($urandom_range(0, 5))
      0, 1: id = svpf_pkg::ID_ONE;
      2, 3: id = svpf_pkg::ID_TWO;
      4: id = 8'($urandom);
      default: id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
    return id;
  endfunction

  function automatic logic signed [svpf_pkg::ANGLE_W-1:0] pick_angle(
    logic [svpf_pkg::ID_W-1:0] id
  );
    int bound;
    logic signed [svpf_pkg::ANGLE_W-1:0] a;
    case ($urandom_range(0, 5))
      0, 1: a = 16'($urandom);
      2: a = 16'($urandom_range(0, svpf_pkg::FULL_MAX));
      3: begin
        if (id == svpf_pkg::ID_ONE) begin
          bound = $urandom_range(0, 1) ? int'(one_lo) : int'(one_hi);
        end else if (id == svpf_pkg::ID_TWO) begin
          bound = $urandom_range(0, 1) ? int'(two_lo) : int'(two_hi);
        end else begin
          bound = $urandom_range(0, 1) ? 0 : int'(svpf_pkg::FULL_MAX);
        end
        bound = bound + int'($urandom_range(0, 4)) - 2;
        a = bound[svpf_pkg::ANGLE_W-1:0];
      end
      4: a = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: a = $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
    endcase
    return a;
  endfunction

  task automatic push_cmd(svpf_pkg::op_e op, logic [svpf_pkg::ID_W-1:0] ida,
                          logic signed [svpf_pkg::ANGLE_W-1:0] anga,
                          logic [svpf_pkg::ID_W-1:0] idb,
                          logic signed [svpf_pkg::ANGLE_W-1:0] angb);
    servo_cmd_t c;
    c.op = op;
    c.id_a = ida;
    c.angle_a = anga;
    c.id_b = idb;
    c.angle_b = angb;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  task automatic queue_random(int count);
    logic [svpf_pkg::ID_W-1:0] ida;
    logic [svpf_pkg::ID_W-1:0] idb;
    for (int k = 0; k < count; k++) begin
      ida = pick_id();
      idb = pick_id();
      push_cmd(svpf_pkg::op_e'($urandom_range(0, 1)), ida, pick_angle(ida), idb,
               pick_angle(idb));
    end
  endtask

  task automatic write_reg(logic [svpf_pkg::CFG_IDX_W-1:0] idx,
                           logic [svpf_pkg::CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      svpf_pkg::CFG_ONE_MIN: one_lo = value[svpf_pkg::POS_W-1:0];
      svpf_pkg::CFG_ONE_MAX: one_hi = value[svpf_pkg::POS_W-1:0];
      svpf_pkg::CFG_TWO_MIN: two_lo = value[svpf_pkg::POS_W-1:0];
      svpf_pkg::CFG_TWO_MAX: two_hi = value[svpf_pkg::POS_W-1:0];
      svpf_pkg::CFG_MOVE_TIME: move_ticks = value[svpf_pkg::TIME_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    do @(negedge clk); while (cmds_taken != cmds_queued || bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        next_cmd = cmd_backlog.pop_front();
        operation <= next_cmd.op;
        servo_id_a <= next_cmd.id_a;
        angle_a <= next_cmd.angle_a;
        servo_id_b <= next_cmd.id_b;
        angle_b <= next_cmd.angle_b;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && bytes_seen >= LONG_HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 4));
        mode_left = $urandom_range(20, 150);
        stall_pattern = 8'($urandom);
      end else begin
        mode_left--;
      end
      pattern_pos = (pattern_pos + 1) % 8;
      case (stall_mode)
        FLOW: out_stall <= 1'b0;
        COIN: out_stall <= 1'($urandom_range(0, 1));
        PATTERN: out_stall <= stall_pattern[pattern_pos];
        CHOKE: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (mode_left < 40);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        frame_packet('{svpf_pkg::op_e'(operation), servo_id_a, angle_a, servo_id_b,
                       angle_b});
        cmds_taken++;
      end
      if (out_valid && !out_stall) begin
        bytes_seen++;
        if (bytes_due.size() == 0) begin
          $error("packet_byte: expected nothing, got %02h (last_byte %0b)",
                 packet_byte, last_byte);
          fail_count++;
        end else begin
          due_byte = bytes_due.pop_front();
          if (packet_byte !== due_byte.data) begin
            $error("packet_byte: expected %02h, got %02h", due_byte.data, packet_byte);
            fail_count++;
          end
          if (last_byte !== due_byte.last) begin
            $error("last_byte: expected %0b, got %0b", due_byte.last, last_byte);
            fail_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_ONE, 16'sh8000, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_ONE, 16'sh7FFF, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_ONE, 16'sd599, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_ONE, 16'sd600, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_ONE, 16'sd3600, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_ONE, 16'sd3601, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_TWO, 16'sd1299, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_TWO, 16'sd4095, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_TWO, 16'sd4096, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, 8'h00, 16'shFFFF, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, 8'hFF, 16'sd4096, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, 8'd3, 16'sd0, 8'h00, 16'sh0000);
    push_cmd(svpf_pkg::OP_SINGLE, 8'h00, 16'sd4095, 8'hFF, 16'sh8000);
    push_cmd(svpf_pkg::OP_SINGLE, 8'hAA, 16'sh0555, svpf_pkg::ID_TWO, 16'sh7FFF);
    push_cmd(svpf_pkg::OP_SYNC, svpf_pkg::ID_ONE, 16'sh8000, svpf_pkg::ID_TWO, 16'sh7FFF);
    push_cmd(svpf_pkg::OP_SYNC, 8'hFF, 16'sh7FFF, 8'h00, 16'sh8000);
    push_cmd(svpf_pkg::OP_SYNC, svpf_pkg::ID_TWO, 16'sd0, svpf_pkg::ID_ONE, 16'sd4095);
    push_cmd(svpf_pkg::OP_SYNC, 8'hFE, 16'sh0AAA, 8'hFE, 16'sh0555);
    queue_random(20);
    settle();

    // min above max on id 2, oversized values on 12-bit registers
    write_reg(svpf_pkg::CFG_ONE_MIN, 16'h0000);
    write_reg(svpf_pkg::CFG_ONE_MAX, 16'hFFFF);
    write_reg(svpf_pkg::CFG_TWO_MIN, 16'h0FFF);
    write_reg(svpf_pkg::CFG_TWO_MAX, 16'h0000);
    write_reg(svpf_pkg::CFG_MOVE_TIME, 16'hFFFF);
    cfg_write <= 1'b0;
    push_cmd(svpf_pkg::OP_SYNC, svpf_pkg::ID_TWO, 16'sh8000, svpf_pkg::ID_TWO, 16'sh7FFF);
    push_cmd(svpf_pkg::OP_SINGLE, svpf_pkg::ID_TWO, 16'sd2048, 8'h00, 16'sh0000);
    queue_random(25);
    settle();

    write_reg(svpf_pkg::CFG_ONE_MIN, 16'($urandom_range(0, 65535)));
    write_reg(svpf_pkg::CFG_ONE_MAX, 16'($urandom_range(0, 65535)));
    write_reg(svpf_pkg::CFG_TWO_MIN, 16'($urandom_range(0, 65535)));
    write_reg(svpf_pkg::CFG_TWO_MAX, 16'($urandom_range(0, 65535)));
    write_reg(svpf_pkg::CFG_MOVE_TIME, 16'($urandom_range(0, 65535)));
    write_reg(BAD_INDEX_LO, 16'($urandom_range(0, 65535)));
    write_reg(BAD_INDEX_HI, 16'($urandom_range(0, 65535)));
    cfg_write <= 1'b0;
    queue_random(30);
    settle();

    write_reg(svpf_pkg::CFG_ONE_MIN, 16'd2048);
    write_reg(svpf_pkg::CFG_ONE_MAX, 16'd2048);
    write_reg(svpf_pkg::CFG_TWO_MIN, 16'd0);
    write_reg(svpf_pkg::CFG_TWO_MAX, 16'd0);
    write_reg(svpf_pkg::CFG_MOVE_TIME, 16'd0);
    write_reg(BAD_INDEX_LO, 16'hFFFF);
    write_reg(BAD_INDEX_HI, 16'h1234);
    cfg_write <= 1'b0;
    queue_random(25);
    settle();

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/svpf_pkg.sv
rtl/svpf_front.sv
rtl/svpf_queue.sv
rtl/svpf_back.sv
rtl/servo_position_packet_framer.sv
tb/servo_position_packet_framer_test.sv
